@@ src/lrg_pkg.sv @@
// shared constants, codes and controller/datapath types for lane risk guidance
`timescale 1ns / 1ps
package lrg_pkg;

  // default score format
  localparam int DEF_FRAC_BITS  = 11;
  localparam int DEF_SCORE_BITS = 16;

  // fixed field widths
  localparam int DIM_W   = 13;
  localparam int COORD_W = 14;
  localparam int OUT_W   = 16;
  localparam int DIV_W   = 2 * DIM_W + 1;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register map
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    GD_KEEP  = 2'd0,
    GD_LEFT  = 2'd1,
    GD_RIGHT = 2'd2,
    GD_SLOW  = 2'd3
  } guidance_t;

  typedef enum logic [1:0] {
    LN_LEFT   = 2'd0,
    LN_CENTER = 2'd1,
    LN_RIGHT  = 2'd2
  } lane_t;

  typedef enum logic [1:0] {
    DS_A = 2'd0,
    DS_B = 2'd1,
    DS_C = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLAMP,
    CMD_MUL,
    CMD_DIV_GO,
    CMD_DIV_TAKE,
    CMD_C45_GO,
    CMD_RISK,
    CMD_R13_GO,
    CMD_R13_TAKE,
    CMD_ADD,
    CMD_BLEND_GO,
    CMD_BLEND_TAKE,
    CMD_DECIDE
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_C45_GO,
    ST_C45_WAIT,
    ST_R13_GO,
    ST_R13_WAIT,
    ST_ADD,
    ST_FRAME,
    ST_BLEND_GO,
    ST_BLEND_WAIT,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    cmd_t     op;
    div_sel_t dsel;
    lane_t    lane;
  } dp_cmd_t;

  typedef struct packed {
    logic keep;
    logic big;
    logic frame_end;
    logic div_done;
    logic d10_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/lrg_stream_if.sv @@
// request channel interfaces for boxes in and guidance out
`timescale 1ns / 1ps
interface lrg_box_if;
  logic                       valid;
  logic                       ready;
  logic                       box_valid;
  logic                       is_vehicle;
  logic [lrg_pkg::COORD_W-1:0] box_left;
  logic [lrg_pkg::COORD_W-1:0] box_top;
  logic [lrg_pkg::COORD_W-1:0] box_right;
  logic [lrg_pkg::COORD_W-1:0] box_bottom;
  logic                       frame_end;

  modport source (output valid, box_valid, is_vehicle, box_left, box_top, box_right,
                  box_bottom, frame_end, input ready);
  modport sink (input valid, box_valid, is_vehicle, box_left, box_top, box_right,
                box_bottom, frame_end, output ready);
endinterface

interface lrg_guide_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                guidance;
  logic [lrg_pkg::OUT_W-1:0] score_left;
  logic [lrg_pkg::OUT_W-1:0] score_center;
  logic [lrg_pkg::OUT_W-1:0] score_right;

  modport source (output valid, guidance, score_left, score_center, score_right,
                  input ready);
  modport sink (input valid, guidance, score_left, score_center, score_right,
                output ready);
endinterface

@@ src/lrg_div.sv @@
// restoring fraction divider, one quotient bit per cycle, numerator at most divisor
`timescale 1ns / 1ps
module lrg_div #(
  parameter int QW = lrg_pkg::DEF_FRAC_BITS + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lrg_pkg::DIV_W-1:0] num,
  input  logic [lrg_pkg::DIV_W-1:0] den,
  output logic [QW-1:0]             quo,
  output logic                      done
);
  localparam int RW = lrg_pkg::DIV_W;
  localparam int CNTW = $clog2(QW + 1);

  logic [RW-1:0]   rem;
  logic [RW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            ge;
  logic [RW-1:0]   rem_sub;

  // trial subtract of the current partial remainder
  assign ge      = rem >= dvs;
  assign rem_sub = ge ? rem - dvs : rem;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= {rem_sub[RW-2:0], 1'b0};
      quo <= {quo[QW-2:0], ge};
    end
  end
endmodule

@@ src/lrg_div10.sv @@
// divide by ten through a reciprocal multiply and one correction, each step registered
`timescale 1ns / 1ps
module lrg_div10 #(
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] x,
  output logic [DW-1:0] q,
  output logic          done
);
  localparam int K = DW + 3;
  localparam logic [63:0] RECIP = (64'd1 << K) / 64'd10;
  localparam logic [K-1:0] M = RECIP[K-1:0];

  logic [DW+K-1:0] prod;
  logic [DW-1:0]   xr;
  logic            v1;
  logic [DW-1:0]   q0;
  logic [DW+3:0]   rem;

  // estimate is low by at most one
  assign q0  = prod[DW+K-1:K];
  assign rem = (DW+4)'(xr) - (DW+4)'(q0) * (DW+4)'(10);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

  // multiply stage, then correction stage
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= (DW+K)'(x) * (DW+K)'(M);
      xr   <= x;
    end
    if (v1) begin
      q <= (rem >= (DW+4)'(10)) ? q0 + 1'b1 : q0;
    end
  end
endmodule

@@ src/lrg_dp.sv @@
// datapath: clamp, area and ratio arithmetic, region sums, smoothing, decision
`timescale 1ns / 1ps
module lrg_dp #(
  parameter int SCORE_FRAC_BITS = lrg_pkg::DEF_FRAC_BITS,
  parameter int SCORE_BITS      = lrg_pkg::DEF_SCORE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lrg_pkg::dp_cmd_t            cmd,
  output lrg_pkg::dp_status_t         status,
  input  logic [lrg_pkg::DIM_W-1:0]   image_width,
  input  logic [lrg_pkg::DIM_W-1:0]   image_height,
  input  logic                        box_valid,
  input  logic                        is_vehicle,
  input  logic [lrg_pkg::COORD_W-1:0] box_left,
  input  logic [lrg_pkg::COORD_W-1:0] box_top,
  input  logic [lrg_pkg::COORD_W-1:0] box_right,
  input  logic [lrg_pkg::COORD_W-1:0] box_bottom,
  input  logic                        frame_end,
  input  logic                        out_ready,
  output logic                        out_valid,
  output lrg_pkg::guidance_t          guidance,
  output logic [SCORE_BITS-1:0]       score_left,
  output logic [SCORE_BITS-1:0]       score_center,
  output logic [SCORE_BITS-1:0]       score_right
);
  localparam int F     = SCORE_FRAC_BITS;
  localparam int SB    = SCORE_BITS;
  localparam int QW    = F + 1;
  localparam int RISKW = F + 4;
  localparam int DW    = (F + 8 > SB + 4) ? F + 8 : SB + 4;
  localparam int CMPW  = ((RISKW > SB) ? RISKW : SB) + 1;
  localparam int CW    = ((SB > F + 1) ? SB : F + 1) + 4;
  localparam int DIMW  = lrg_pkg::DIM_W;
  localparam int DVW   = lrg_pkg::DIV_W;
  localparam logic [SB-1:0] SMAX = '1;
  localparam logic [CW-1:0] UNIT = CW'(1) << F;

  // latched item
  logic                        bv_q, veh_q, fe_q;
  logic [lrg_pkg::COORD_W-1:0] left_q, top_q, right_q, bottom_q;

  // clamped box
  logic [DIMW-1:0] w_q, h_q, y1_q;
  logic [DIMW:0]   s_q;
  logic            keep_q;
  lrg_pkg::lane_t  region_q;

  // products and quotients
  logic [2*DIMW-1:0] area_q, full_q;
  logic [DIMW-1:0]   dist_q;
  logic [QW-1:0]     qa, qb, qc;
  logic [RISKW-1:0]  risk;

  // running state
  logic [SB-1:0] sums [3];
  logic [SB-1:0] smooth [3];

  // clamp arithmetic
  logic signed [15:0] l_s, t_s, r_s, b_s, wm1_s, hm1_s;
  logic signed [15:0] x0_s, y0_s, x1_s, y1_s, w_s, h_s;
  logic [17:0]        y20, h7, h13;
  logic [DIMW:0]      s_c;
  logic [15:0]        s3, w2, w4;
  logic               keep_c;
  lrg_pkg::lane_t     region_c;

  assign l_s   = 16'($signed(left_q));
  assign t_s   = 16'($signed(top_q));
  assign r_s   = 16'($signed(right_q));
  assign b_s   = 16'($signed(bottom_q));
  assign wm1_s = $signed({3'b000, image_width}) - 16'sd1;
  assign hm1_s = $signed({3'b000, image_height}) - 16'sd1;
  assign x0_s  = (l_s < 16'sd0) ? 16'sd0 : l_s;
  assign y0_s  = (t_s < 16'sd0) ? 16'sd0 : t_s;
  assign x1_s  = (r_s > wm1_s) ? wm1_s : r_s;
  assign y1_s  = (b_s > hm1_s) ? hm1_s : b_s;
  assign w_s   = x1_s - x0_s;
  assign h_s   = y1_s - y0_s;
  assign y20   = 18'(y1_s[DIMW-1:0]) * 18'd20;
  assign h7    = 18'(image_height) * 18'd7;
  assign h13   = 18'(image_height) * 18'd13;
  assign s_c   = (DIMW+1)'(x0_s[DIMW-1:0]) + (DIMW+1)'(x1_s[DIMW-1:0]);
  assign s3    = 16'(s_c) * 16'd3;
  assign w2    = 16'(image_width) << 1;
  assign w4    = 16'(image_width) << 2;

  assign keep_c = bv_q && veh_q && (image_width != '0) && (image_height != '0) &&
                  (w_s > 16'sd0) && (h_s > 16'sd0) && (y20 >= h7);

  always_comb begin
    if (s3 < w2) begin
      region_c = lrg_pkg::LN_LEFT;
    end else if (s3 < w4) begin
      region_c = lrg_pkg::LN_CENTER;
    end else begin
      region_c = lrg_pkg::LN_RIGHT;
    end
  end

  // centre distance term
  logic [DIMW:0] sw;
  logic [DIMW:0] w_e;
  assign w_e = (DIMW+1)'(image_width);
  assign sw  = (s_q >= w_e) ? s_q - w_e : w_e - s_q;

  // large-and-low scaling condition
  logic [31:0] area50;
  assign area50     = 32'(area_q) * 32'd50;
  assign status.big = (area50 > 32'(full_q)) && ((18'(y1_q) * 18'd20) > h13);

  // shared fraction divider
  logic            div_start;
  logic [DVW-1:0]  div_num, div_den;
  logic [QW-1:0]   div_q;
  logic            div_done;

  assign div_start = (cmd.op == lrg_pkg::CMD_DIV_GO);

  always_comb begin
    unique case (cmd.dsel)
      lrg_pkg::DS_A: begin
        div_num = DVW'(area_q);
        div_den = DVW'(full_q);
      end
      lrg_pkg::DS_B: begin
        div_num = DVW'(y1_q);
        div_den = DVW'(image_height);
      end
      lrg_pkg::DS_C: begin
        div_num = DVW'(dist_q);
        div_den = DVW'(image_width);
      end
      default: begin
        div_num = '0;
        div_den = '1;
      end
    endcase
  end

  lrg_div #(.QW(QW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  // shared divide-by-ten unit
  logic          d10_start;
  logic [DW-1:0] d10_x, d10_q;
  logic          d10_done;
  logic [1:0]    ln;
  assign ln = cmd.lane;

  always_comb begin
    d10_start = 1'b0;
    d10_x     = '0;
    case (cmd.op)
      lrg_pkg::CMD_C45_GO: begin
        d10_start = 1'b1;
        d10_x     = DW'({qc, 3'b000});
      end
      lrg_pkg::CMD_R13_GO: begin
        d10_start = 1'b1;
        d10_x     = DW'(risk) * DW'(13);
      end
      lrg_pkg::CMD_BLEND_GO: begin
        d10_start = 1'b1;
        d10_x     = (DW'(smooth[ln]) << 3) - DW'(smooth[ln]) +
                    (DW'(sums[ln]) << 1) + DW'(sums[ln]);
      end
      default: begin
        d10_start = 1'b0;
      end
    endcase
  end

  lrg_div10 #(.DW(DW)) u_div10 (
    .clk   (clk),
    .rst   (rst),
    .start (d10_start),
    .x     (d10_x),
    .q     (d10_q),
    .done  (d10_done)
  );

  // risk saturation and region add
  logic [CMPW-1:0] risk_e;
  logic [SB-1:0]   risk_sat;
  logic [SB:0]     sum_add;
  assign risk_e   = CMPW'(risk);
  assign risk_sat = (risk_e > CMPW'(SMAX)) ? SMAX : SB'(risk);
  assign sum_add  = (SB+1)'(sums[region_q]) + (SB+1)'(risk_sat);

  // decision on smoothed scores
  logic [CW-1:0]      l5, c5, r5, diff;
  lrg_pkg::guidance_t gd_c;
  assign l5   = CW'(smooth[0]) * CW'(5);
  assign c5   = CW'(smooth[1]) * CW'(5);
  assign r5   = CW'(smooth[2]) * CW'(5);
  assign diff = (smooth[0] > smooth[2]) ? CW'(smooth[0] - smooth[2]) :
                                          CW'(smooth[2] - smooth[0]);

  always_comb begin
    if (c5 < CW'(13) * UNIT) begin
      gd_c = lrg_pkg::GD_KEEP;
    end else if ((l5 > CW'(11) * UNIT) && (c5 > CW'(11) * UNIT) &&
                 (r5 > CW'(11) * UNIT)) begin
      gd_c = lrg_pkg::GD_SLOW;
    end else if ((l5 + CW'(4) * UNIT < c5) && (smooth[0] < smooth[2])) begin
      gd_c = lrg_pkg::GD_LEFT;
    end else if ((r5 + CW'(4) * UNIT < c5) && (smooth[2] < smooth[0])) begin
      gd_c = lrg_pkg::GD_RIGHT;
    end else begin
      gd_c = lrg_pkg::GD_SLOW;
    end
    // anti-jitter override
    if (((diff << 2) < UNIT) && (c5 < CW'(14) * UNIT)) begin
      gd_c = lrg_pkg::GD_KEEP;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      lrg_pkg::CMD_LOAD: begin
        bv_q     <= box_valid;
        veh_q    <= is_vehicle;
        left_q   <= box_left;
        top_q    <= box_top;
        right_q  <= box_right;
        bottom_q <= box_bottom;
        fe_q     <= frame_end;
      end
      lrg_pkg::CMD_CLAMP: begin
        keep_q   <= keep_c;
        w_q      <= w_s[DIMW-1:0];
        h_q      <= h_s[DIMW-1:0];
        y1_q     <= y1_s[DIMW-1:0];
        s_q      <= s_c;
        region_q <= region_c;
      end
      lrg_pkg::CMD_MUL: begin
        area_q <= (2*DIMW)'(w_q) * (2*DIMW)'(h_q);
        full_q <= (2*DIMW)'(image_width) * (2*DIMW)'(image_height);
        dist_q <= (w_e > sw) ? DIMW'(w_e - sw) : '0;
      end
      lrg_pkg::CMD_DIV_TAKE: begin
        unique case (cmd.dsel)
          lrg_pkg::DS_A: qa <= div_q;
          lrg_pkg::DS_B: qb <= div_q;
          lrg_pkg::DS_C: qc <= div_q;
          default:       qa <= div_q;
        endcase
      end
      lrg_pkg::CMD_RISK: begin
        risk <= RISKW'(qa) * RISKW'(3) + ((RISKW'(qb) * RISKW'(3)) >> 1) +
                RISKW'(d10_q);
      end
      lrg_pkg::CMD_R13_TAKE: begin
        risk <= RISKW'(d10_q);
      end
      default: begin
      end
    endcase
  end

  // running sums and smoothed scores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sums[i]   <= '0;
        smooth[i] <= '0;
      end
    end else begin
      case (cmd.op)
        lrg_pkg::CMD_ADD: begin
          sums[region_q] <= sum_add[SB] ? SMAX : sum_add[SB-1:0];
        end
        lrg_pkg::CMD_BLEND_TAKE: begin
          smooth[ln] <= SB'(d10_q);
        end
        lrg_pkg::CMD_DECIDE: begin
          for (int i = 0; i < 3; i++) begin
            sums[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == lrg_pkg::CMD_DECIDE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lrg_pkg::CMD_DECIDE) begin
      guidance     <= gd_c;
      score_left   <= smooth[0];
      score_center <= smooth[1];
      score_right  <= smooth[2];
    end
  end

  assign status.keep      = keep_q;
  assign status.frame_end = fe_q;
  assign status.div_done  = div_done;
  assign status.d10_done  = d10_done;
  assign status.out_free  = !out_valid || out_ready;
endmodule

@@ src/lrg_ctrl.sv @@
// controller: sequences one item through the datapath
`timescale 1ns / 1ps
module lrg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lrg_pkg::dp_status_t status,
  output lrg_pkg::dp_cmd_t    cmd
);
  lrg_pkg::state_t   state, state_next;
  lrg_pkg::div_sel_t dsel, dsel_next;
  lrg_pkg::lane_t    lane, lane_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrg_pkg::ST_IDLE;
      dsel  <= lrg_pkg::DS_A;
      lane  <= lrg_pkg::LN_LEFT;
    end else begin
      state <= state_next;
      dsel  <= dsel_next;
      lane  <= lane_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    dsel_next  = dsel;
    lane_next  = lane;
    in_ready   = 1'b0;
    cmd.op     = lrg_pkg::CMD_NONE;
    cmd.dsel   = dsel;
    cmd.lane   = lane;
    unique case (state)
      lrg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = lrg_pkg::CMD_LOAD;
          state_next = lrg_pkg::ST_CLAMP;
        end
      end
      lrg_pkg::ST_CLAMP: begin
        cmd.op     = lrg_pkg::CMD_CLAMP;
        state_next = lrg_pkg::ST_MUL;
      end
      lrg_pkg::ST_MUL: begin
        cmd.op = lrg_pkg::CMD_MUL;
        if (status.keep) begin
          dsel_next  = lrg_pkg::DS_A;
          state_next = lrg_pkg::ST_DIV_GO;
        end else begin
          state_next = lrg_pkg::ST_FRAME;
        end
      end
      lrg_pkg::ST_DIV_GO: begin
        cmd.op     = lrg_pkg::CMD_DIV_GO;
        state_next = lrg_pkg::ST_DIV_WAIT;
      end
      lrg_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.op = lrg_pkg::CMD_DIV_TAKE;
          unique case (dsel)
            lrg_pkg::DS_A: begin
              dsel_next  = lrg_pkg::DS_B;
              state_next = lrg_pkg::ST_DIV_GO;
            end
            lrg_pkg::DS_B: begin
              dsel_next  = lrg_pkg::DS_C;
              state_next = lrg_pkg::ST_DIV_GO;
            end
            default: begin
              state_next = lrg_pkg::ST_C45_GO;
            end
          endcase
        end
      end
      lrg_pkg::ST_C45_GO: begin
        cmd.op     = lrg_pkg::CMD_C45_GO;
        state_next = lrg_pkg::ST_C45_WAIT;
      end
      lrg_pkg::ST_C45_WAIT: begin
        if (status.d10_done) begin
          cmd.op     = lrg_pkg::CMD_RISK;
          state_next = status.big ? lrg_pkg::ST_R13_GO : lrg_pkg::ST_ADD;
        end
      end
      lrg_pkg::ST_R13_GO: begin
        cmd.op     = lrg_pkg::CMD_R13_GO;
        state_next = lrg_pkg::ST_R13_WAIT;
      end
      lrg_pkg::ST_R13_WAIT: begin
        if (status.d10_done) begin
          cmd.op     = lrg_pkg::CMD_R13_TAKE;
          state_next = lrg_pkg::ST_ADD;
        end
      end
      lrg_pkg::ST_ADD: begin
        cmd.op     = lrg_pkg::CMD_ADD;
        state_next = lrg_pkg::ST_FRAME;
      end
      lrg_pkg::ST_FRAME: begin
        if (status.frame_end) begin
          lane_next  = lrg_pkg::LN_LEFT;
          state_next = lrg_pkg::ST_BLEND_GO;
        end else begin
          state_next = lrg_pkg::ST_IDLE;
        end
      end
      lrg_pkg::ST_BLEND_GO: begin
        cmd.op     = lrg_pkg::CMD_BLEND_GO;
        state_next = lrg_pkg::ST_BLEND_WAIT;
      end
      lrg_pkg::ST_BLEND_WAIT: begin
        if (status.d10_done) begin
          cmd.op = lrg_pkg::CMD_BLEND_TAKE;
          unique case (lane)
            lrg_pkg::LN_LEFT: begin
              lane_next  = lrg_pkg::LN_CENTER;
              state_next = lrg_pkg::ST_BLEND_GO;
            end
            lrg_pkg::LN_CENTER: begin
              lane_next  = lrg_pkg::LN_RIGHT;
              state_next = lrg_pkg::ST_BLEND_GO;
            end
            default: begin
              state_next = lrg_pkg::ST_DECIDE;
            end
          endcase
        end
      end
      lrg_pkg::ST_DECIDE: begin
        if (status.out_free) begin
          cmd.op     = lrg_pkg::CMD_DECIDE;
          state_next = lrg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrg_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

@@ src/lane_risk_guidance_top.sv @@
// top level: lane risk guidance with configuration registers
// an item is taken only in idle; a dropped box or bare frame mark passes load, clamp, multiply
// and the frame check; a kept box adds three passes of the shared bit-serial divider and a
// divide-by-ten pass, and a second divide-by-ten pass if large and low
// a frame end adds smoothing through the divide-by-ten unit and the decision
// synchronous reset clears sums, scores and control and restores width 640, height 480
`timescale 1ns / 1ps
module lane_risk_guidance_top #(
  parameter int SCORE_FRAC_BITS = lrg_pkg::DEF_FRAC_BITS,
  parameter int SCORE_BITS      = lrg_pkg::DEF_SCORE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  lrg_box_if.sink                     box_in,
  lrg_guide_if.source                 guide_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrg_pkg::PADDR_W-1:0] paddr,
  input  logic [lrg_pkg::PDATA_W-1:0] pwdata,
  output logic [lrg_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  logic [lrg_pkg::DIM_W-1:0] image_width, image_height;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lrg_pkg::WIDTH_RST;
      image_height <= lrg_pkg::HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == lrg_pkg::REG_WIDTH) begin
        image_width <= pwdata[lrg_pkg::DIM_W-1:0];
      end else begin
        image_height <= pwdata[lrg_pkg::DIM_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lrg_pkg::REG_HEIGHT) ?
                  lrg_pkg::PDATA_W'(image_height) : lrg_pkg::PDATA_W'(image_width);

  lrg_pkg::dp_cmd_t    cmd;
  lrg_pkg::dp_status_t status;
  lrg_pkg::guidance_t  gd;
  logic [SCORE_BITS-1:0] sl, sc, sr;

  lrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (box_in.valid),
    .in_ready (box_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lrg_dp #(
    .SCORE_FRAC_BITS (SCORE_FRAC_BITS),
    .SCORE_BITS      (SCORE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .image_width  (image_width),
    .image_height (image_height),
    .box_valid    (box_in.box_valid),
    .is_vehicle   (box_in.is_vehicle),
    .box_left     (box_in.box_left),
    .box_top      (box_in.box_top),
    .box_right    (box_in.box_right),
    .box_bottom   (box_in.box_bottom),
    .frame_end    (box_in.frame_end),
    .out_ready    (guide_out.ready),
    .out_valid    (guide_out.valid),
    .guidance     (gd),
    .score_left   (sl),
    .score_center (sc),
    .score_right  (sr)
  );

  // low bits of each score
  assign guide_out.guidance     = gd;
  assign guide_out.score_left   = lrg_pkg::OUT_W'(sl);
  assign guide_out.score_center = lrg_pkg::OUT_W'(sc);
  assign guide_out.score_right  = lrg_pkg::OUT_W'(sr);
endmodule

@@ src/lrg_checker.sv @@
// port-level checks on the guidance top level and their bind
`timescale 1ns / 1ps
module lrg_checker #(
  parameter int SCORE_FRAC_BITS = lrg_pkg::DEF_FRAC_BITS,
  parameter int SCORE_BITS      = lrg_pkg::DEF_SCORE_BITS
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_frame_end,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                guidance,
  input logic [lrg_pkg::OUT_W-1:0] score_left,
  input logic [lrg_pkg::OUT_W-1:0] score_center,
  input logic [lrg_pkg::OUT_W-1:0] score_right
);
  localparam logic FULL_SCORE = (SCORE_BITS <= lrg_pkg::OUT_W);
  localparam logic [31:0] UNIT = 32'd1 << SCORE_FRAC_BITS;

  logic [31:0] c5;
  assign c5 = 32'(score_center) * 32'd5;

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // an item without frame end raises no result
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_frame_end |=> !$rose(out_valid))
    else $error("result without frame end");

  // low centre score keeps the lane
  a_keep_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && FULL_SCORE && (c5 < 32'd13 * UNIT) |-> guidance == lrg_pkg::GD_KEEP)
    else $error("low centre score must keep lane");

  // balanced sides with moderate centre keep the lane
  a_keep_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && FULL_SCORE && (score_left == score_right) && (c5 < 32'd14 * UNIT)
    |-> guidance == lrg_pkg::GD_KEEP)
    else $error("balanced sides must keep lane");
endmodule

bind lane_risk_guidance_top lrg_checker #(
  .SCORE_FRAC_BITS (SCORE_FRAC_BITS),
  .SCORE_BITS      (SCORE_BITS)
) u_lrg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (box_in.valid),
  .in_ready     (box_in.ready),
  .in_frame_end (box_in.frame_end),
  .out_valid    (guide_out.valid),
  .out_ready    (guide_out.ready),
  .guidance     (guide_out.guidance),
  .score_left   (guide_out.score_left),
  .score_center (guide_out.score_center),
  .score_right  (guide_out.score_right)
);

@@ dv/tb.sv @@
// self-checking testbench for lane risk guidance: directed table, random frames, stalls
`timescale 1ns / 1ps
module tb;
  import lrg_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;
  localparam longint UNIT = longint'(1) << FRAC;
  localparam longint SMAX = (longint'(1) << DEF_SCORE_BITS) - 1;
  localparam int N_RANDOM = 1850;

  // one box request and one guidance result
  typedef struct packed {
    logic bv;
    logic veh;
    logic [COORD_W-1:0] l, t, r, b;
    logic fe;
  } box_req_t;

  typedef struct packed {
    guidance_t g;
    logic [OUT_W-1:0] sl, sc, sr;
  } guide_res_t;

  // directed row: request, optional typed expectation
  typedef struct packed {
    box_req_t req;
    logic has_exp;
    guide_res_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  lrg_box_if box_ch();
  lrg_guide_if guide_ch();

  lane_risk_guidance_top u_top (
    .clk(clk), .rst(rst), .box_in(box_ch.sink), .guide_out(guide_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  longint img_w = 640, img_h = 480;
  longint acc_l, acc_c, acc_r, sm_l, sm_c, sm_r;
  guide_res_t guide_q[$];
  int errors = 0;
  logic stall_long = 1'b0;
  logic feeding = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

  function automatic longint sx14(logic [COORD_W-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sat16(longint v);
    return v > SMAX ? SMAX : v;
  endfunction

  // add one box's risk to its lane sum
  function automatic void accumulate_box(box_req_t q);
    longint x0, y0, x1, y1, w, h, s, d, area, full, a, b, c, risk;
    if (img_w <= 0 || img_h <= 0) return;
    x0 = sx14(q.l); if (x0 < 0) x0 = 0;
    y0 = sx14(q.t); if (y0 < 0) y0 = 0;
    x1 = sx14(q.r); if (x1 > img_w - 1) x1 = img_w - 1;
    y1 = sx14(q.b); if (y1 > img_h - 1) y1 = img_h - 1;
    w = x1 - x0;
    h = y1 - y0;
    if (w <= 0 || h <= 0) return;
    if (20 * y1 < 7 * img_h) return;
    area = w * h;
    full = img_w * img_h;
    s = x0 + x1;
    d = s - img_w; if (d < 0) d = -d;
    d = img_w - d; if (d < 0) d = 0;
    a = (area * UNIT) / full;
    b = (y1 * UNIT) / img_h;
    c = (d * UNIT) / img_w;
    risk = 3 * a + (3 * b) / 2 + (4 * c) / 5;
    if (50 * area > full && 20 * y1 > 13 * img_h) risk = (risk * 13) / 10;
    risk = sat16(risk);
    if (3 * s < 2 * img_w) acc_l = sat16(acc_l + risk);
    else if (3 * s < 4 * img_w) acc_c = sat16(acc_c + risk);
    else acc_r = sat16(acc_r + risk);
  endfunction

  function automatic guidance_t pick_guidance(longint l, longint c, longint r);
    guidance_t g;
    longint diff;
    if (5 * c < 13 * UNIT) g = GD_KEEP;
    else if (5 * l > 11 * UNIT && 5 * c > 11 * UNIT && 5 * r > 11 * UNIT) g = GD_SLOW;
    else if (5 * l + 4 * UNIT < 5 * c && l < r) g = GD_LEFT;
    else if (5 * r + 4 * UNIT < 5 * c && r < l) g = GD_RIGHT;
    else g = GD_SLOW;
    diff = l > r ? l - r : r - l;
    if (4 * diff < UNIT && 5 * c < 14 * UNIT) g = GD_KEEP;
    return g;
  endfunction

  // returns 1 and fills res when the request closes a frame
  function automatic bit predict_guidance(box_req_t q, output guide_res_t res);
    res = '0;
    if (q.bv && q.veh) accumulate_box(q);
    if (!q.fe) return 0;
    sm_l = sat16((7 * sm_l + 3 * acc_l) / 10);
    sm_c = sat16((7 * sm_c + 3 * acc_c) / 10);
    sm_r = sat16((7 * sm_r + 3 * acc_r) / 10);
    res.g = pick_guidance(sm_l, sm_c, sm_r);
    res.sl = sm_l[15:0];
    res.sc = sm_c[15:0];
    res.sr = sm_r[15:0];
    acc_l = 0; acc_c = 0; acc_r = 0;
    return 1;
  endfunction

  task automatic write_reg(logic idx, longint val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'({idx, 2'b00}); pwdata <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_WIDTH) img_w = val & 13'h1FFF;
    else img_h = val & 13'h1FFF;
  endtask

  // stops offering, drains expectations, then lets a dropped-box item finish
  task automatic wait_idle();
    box_ch.valid <= 1'b0;
    while (guide_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // valid stays high after an accept so requests can follow back to back
  task automatic send_box(box_req_t q, bit gaps);
    guide_res_t res;
    if (gaps && $urandom_range(0, 3) == 0) begin
      box_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 4))
        @(posedge clk);
    end
    box_ch.valid <= 1'b1;
    {box_ch.box_valid, box_ch.is_vehicle, box_ch.box_left, box_ch.box_top,
     box_ch.box_right, box_ch.box_bottom, box_ch.frame_end} <= q;
    @(posedge clk);
    while (!box_ch.ready) @(posedge clk);
    if (predict_guidance(q, res)) guide_q.push_back(res);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(longint lim);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return COORD_W'($urandom_range(0, 16383));
    if (k == 1) return COORD_W'(-longint'($urandom_range(1, 4096)));
    return COORD_W'($urandom_range(0, lim + 4));
  endfunction

  function automatic box_req_t rand_box(bit fe);
    box_req_t q;
    longint x0, y0;
    q.bv = $urandom_range(0, 9) != 0;
    q.veh = $urandom_range(0, 9) != 0;
    if ($urandom_range(0, 3) == 0) begin
      q.l = rand_coord(img_w); q.t = rand_coord(img_h);
      q.r = rand_coord(img_w); q.b = rand_coord(img_h);
    end else begin
      // well-formed low box, mostly in the lower part of the image
      x0 = $urandom_range(0, img_w > 1 ? img_w - 2 : 0);
      y0 = $urandom_range(0, img_h > 1 ? img_h - 2 : 0);
      q.l = COORD_W'(x0);
      q.r = COORD_W'($urandom_range(x0 + 1, img_w + 8));
      q.t = COORD_W'(y0 / 2);
      q.b = COORD_W'($urandom_range((img_h * 7) / 20, img_h + 8));
    end
    q.fe = fe;
    return q;
  endfunction

  // result checker
  always @(posedge clk) begin
    guide_res_t got, want;
    if (!rst && guide_ch.valid && guide_ch.ready) begin
      got = {guidance_t'(guide_ch.guidance), guide_ch.score_left, guide_ch.score_center,
             guide_ch.score_right};
      if (guide_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = guide_q.pop_front();
        if (got.g != want.g) begin
          $display("%0t guidance exp %0d got %0d", $time, want.g, got.g); errors++;
        end
        if (got.sl != want.sl) begin
          $display("%0t score_left exp %0d got %0d", $time, want.sl, got.sl); errors++;
        end
        if (got.sc != want.sc) begin
          $display("%0t score_center exp %0d got %0d", $time, want.sc, got.sc); errors++;
        end
        if (got.sr != want.sr) begin
          $display("%0t score_right exp %0d got %0d", $time, want.sr, got.sr); errors++;
        end
      end
    end
  end

  // receiver backpressure: random gaps plus one long hold-off
  initial begin
    int n;
    guide_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (stall_long) begin
        guide_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        stall_long = 1'b0;
      end else if (feeding && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, 9) == 0 ? $urandom_range(20, 150) : $urandom_range(1, 4);
        guide_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      guide_ch.ready <= 1'b1;
    end
  end

  // directed rows
  dir_row_t dir_rows[$];

  function automatic dir_row_t row(logic bv, logic veh, int l, int t, int r, int b, logic fe);
    dir_row_t d;
    d = '0;
    d.req = {bv, veh, COORD_W'(l), COORD_W'(t), COORD_W'(r), COORD_W'(b), fe};
    return d;
  endfunction

  initial begin
    dir_row_t d;
    guide_res_t res;
    box_req_t q;
    int cfg, k;
    acc_l = 0; acc_c = 0; acc_r = 0; sm_l = 0; sm_c = 0; sm_r = 0;
    box_ch.valid = 1'b0;
    {box_ch.box_valid, box_ch.is_vehicle, box_ch.box_left, box_ch.box_top,
     box_ch.box_right, box_ch.box_bottom, box_ch.frame_end} = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // bare frame end after reset: all zero, keep
    d = row(0, 0, 0, 0, 0, 0, 1); d.has_exp = 1; d.exp = {GD_KEEP, 48'd0}; dir_rows.push_back(d);
    // non-vehicle and not-valid boxes dropped
    d = row(1, 0, 0, 300, 639, 479, 1); d.has_exp = 1; d.exp = {GD_KEEP, 48'd0};
    dir_rows.push_back(d);
    d = row(0, 1, 0, 300, 639, 479, 1); d.has_exp = 1; d.exp = {GD_KEEP, 48'd0};
    dir_rows.push_back(d);
    // empty and high boxes dropped
    d = row(1, 1, 100, 300, 100, 400, 1); d.has_exp = 1; d.exp = {GD_KEEP, 48'd0};
    dir_rows.push_back(d);
    d = row(1, 1, 100, 0, 200, 100, 1); d.has_exp = 1; d.exp = {GD_KEEP, 48'd0};
    dir_rows.push_back(d);
    // coordinate extremes and lanes
    dir_rows.push_back(row(1, 1, -4096, -4096, 8191, 8191, 0));
    dir_rows.push_back(row(1, 1, 8191, 8191, -4096, -4096, 0));
    dir_rows.push_back(row(1, 1, 0, 200, 150, 470, 0));
    dir_rows.push_back(row(1, 1, 250, 200, 390, 470, 0));
    dir_rows.push_back(row(1, 1, 500, 200, 639, 470, 1));
    // heavy centre load to reach left, right, slow and saturation
    for (k = 0; k < 6; k++) dir_rows.push_back(row(1, 1, 200, 300, 440, 479, 0));
    dir_rows.push_back(row(1, 1, 500, 400, 639, 479, 1));
    for (k = 0; k < 4; k++) dir_rows.push_back(row(1, 1, 200, 300, 440, 479, 0));
    dir_rows.push_back(row(1, 1, 0, 400, 100, 479, 1));
    dir_rows.push_back(row(1, 1, 0, 0, 639, 479, 1));
    dir_rows.push_back(row(1, 1, 168, 168, 168, 168, 1));

    feeding = 1'b1;
    foreach (dir_rows[i]) begin
      send_box(dir_rows[i].req, 1'b0);
      if (dir_rows[i].has_exp) begin
        res = guide_q[$];
        if (res != dir_rows[i].exp) begin
          $display("%0t row %0d exp %h predicted %h", $time, i, dir_rows[i].exp, res);
          errors++;
        end
      end
    end

    // random frames under several geometries, extremes included
    for (cfg = 0; cfg < 6; cfg++) begin
      wait_idle();
      case (cfg)
        0: begin write_reg(REG_WIDTH, 640); write_reg(REG_HEIGHT, 480); end
        1: begin write_reg(REG_WIDTH, 1); write_reg(REG_HEIGHT, 1); end
        2: begin write_reg(REG_WIDTH, 4096); write_reg(REG_HEIGHT, 4096); end
        3: begin write_reg(REG_WIDTH, 8191); write_reg(REG_HEIGHT, 0); end
        4: begin write_reg(REG_WIDTH, 64); write_reg(REG_HEIGHT, 8191); end
        default: begin
          write_reg(REG_WIDTH, $urandom_range(2, 4096));
          write_reg(REG_HEIGHT, $urandom_range(2, 4096));
        end
      endcase
      if (cfg == 2) stall_long = 1'b1;
      for (k = 0; k < N_RANDOM / 6; k++) begin
        q = rand_box($urandom_range(0, 4) == 0);
        send_box(q, k % 200 > 150);
      end
      q = rand_box(1'b1);
      send_box(q, 1'b1);
    end

    feeding = 1'b0;
    wait_idle();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ files.f @@
src/lrg_pkg.sv
src/lrg_stream_if.sv
src/lrg_div.sv
src/lrg_div10.sv
src/lrg_dp.sv
src/lrg_ctrl.sv
src/lane_risk_guidance_top.sv
src/lrg_checker.sv
dv/tb.sv
